// File: design/ntc_pkg.sv
// shared types, constants and a helper function of the thermistor converter
package ntc_pkg;

   // converter geometry
   localparam int ADC_BITS  = 12;
   localparam int CODE_W    = ADC_BITS + 1;
   localparam int LIN_W     = ADC_BITS + 6;
   localparam int OHM_W     = 20;
   localparam int BETA_W    = 14;
   localparam int PROD_W    = LIN_W + OHM_W;
   localparam int EXP_W     = $clog2(PROD_W);
   localparam int MANT_W    = 32;
   localparam int FRAC_W    = 24;
   localparam int LOG_W     = EXP_W + FRAC_W;
   localparam int LOG_STEPS = FRAC_W;
   localparam int QUO_BITS  = 20;
   localparam int DEN_W     = 31;
   localparam int BT_W      = 30;
   localparam int B5_W      = BETA_W + 3;
   localparam int Q4_W      = 15;

   // supply level in codes: 3.3 V of a 3.6 V full scale, times 36
   localparam int TOP_CODE = 33 * (2 ** ADC_BITS);

   // B / 298.15 in Q.24 = 56271*B + round((347*B + 2981) / 5963)
   localparam int BT_INT     = 56271;
   localparam int BT_REM     = 347;
   localparam int BT_RND     = 2981;
   localparam int BT_RECIP   = 11524314;
   localparam int BT_SHIFT   = 36;

   // ln2 in Q.30
   localparam longint LN2_Q30 = 744261118;

   // kelvin/320 to celsius/16: floor((x + 12602) / 20) - 5000
   localparam int Q4_OFFSET  = 12602;
   localparam int DIV5_RECIP = 838861;
   localparam int DIV5_SHIFT = 22;
   localparam int Q4_BIAS    = 5000;

   localparam logic signed [Q4_W-1:0] Q4_MAX  = 15'sd16383;
   localparam logic signed [Q4_W-1:0] Q4_MIN  = -15'sd4480;
   localparam logic signed [Q4_W-1:0] Q4_COLD = -15'sd4370;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 2'd2;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_LOW  = 2'd1,
      ST_HIGH = 2'd2
   } status_type;

   // result status and an optional forced temperature
   typedef struct packed {
      status_type             status;
      logic                   force_out;
      logic signed [Q4_W-1:0] fval;
   } side_type;

   // values derived from configuration
   typedef struct packed {
      logic [OHM_W-1:0] series;
      logic [OHM_W-1:0] nominal;
      logic [B5_W-1:0]  b5;
      logic [BT_W-1:0]  bt;
   } coef_type;

   // log2 chain payload, numerator and denominator side by side
   typedef struct packed {
      side_type            side;
      logic [MANT_W-1:0]   mn;
      logic [MANT_W-1:0]   md;
      logic [EXP_W-1:0]    en;
      logic [EXP_W-1:0]    ed;
      logic [FRAC_W-1:0]   fn;
      logic [FRAC_W-1:0]   fd;
   } log_type;

   // divider chain payload
   typedef struct packed {
      side_type            side;
      logic [DEN_W-1:0]    den;
      logic [DEN_W-1:0]    rem;
      logic [QUO_BITS-1:0] lo;
      logic [QUO_BITS-1:0] quo;
   } div_type;

   // index of the highest set bit
   function automatic logic [EXP_W-1:0] lead_one(input logic [PROD_W-1:0] x);
      logic [EXP_W-1:0] e;
      e = '0;
      for (int i = 0; i < PROD_W; i++) begin
         if (x[i]) e = EXP_W'(i);
      end
      return e;
   endfunction

endpackage

// File: design/ntc_coef.sv
// configuration registers and the values derived from them
module ntc_coef (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [ntc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ntc_pkg::OHM_W-1:0]         csr_data,
   output ntc_pkg::coef_type                 coef
);

   logic [ntc_pkg::BETA_W-1:0] beta_ff;
   logic [ntc_pkg::OHM_W-1:0]  series_ff;
   logic [ntc_pkg::OHM_W-1:0]  nominal_ff;
   logic [ntc_pkg::BETA_W-1:0] beff_in;
   logic [22:0]                v_ff;
   logic [ntc_pkg::BT_W-1:0]   kb_ff;
   logic [ntc_pkg::B5_W-1:0]   b5_ff;
   logic [10:0]                q_ff;
   logic [ntc_pkg::BT_W-1:0]   bt_ff;
   logic [46:0]                vprod_in;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff    <= ntc_pkg::BETA_W'(3450);
         series_ff  <= ntc_pkg::OHM_W'(10000);
         nominal_ff <= ntc_pkg::OHM_W'(10000);
      end else if (csr_valid) begin
         unique case (csr_index)
            ntc_pkg::CSR_BETA:    beta_ff    <= csr_data[ntc_pkg::BETA_W-1:0];
            ntc_pkg::CSR_SERIES:  series_ff  <= csr_data;
            ntc_pkg::CSR_NOMINAL: nominal_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // zero beta behaves as one
   assign beff_in  = (beta_ff == '0) ? ntc_pkg::BETA_W'(1) : beta_ff;
   assign vprod_in = 47'(v_ff) * 47'(ntc_pkg::BT_RECIP);

   // B/298.15 in Q.24 and 5*B, registered after beta_ff through v_ff, q_ff and bt_ff
   always_ff @(posedge clock) begin
      v_ff  <= 23'(23'(beff_in) * 23'(ntc_pkg::BT_REM)) + 23'(ntc_pkg::BT_RND);
      kb_ff <= ntc_pkg::BT_W'(ntc_pkg::BT_W'(beff_in) * ntc_pkg::BT_W'(ntc_pkg::BT_INT));
      b5_ff <= ntc_pkg::B5_W'(ntc_pkg::B5_W'(beff_in) * ntc_pkg::B5_W'(5));
      q_ff  <= vprod_in[46:ntc_pkg::BT_SHIFT];
      bt_ff <= kb_ff + ntc_pkg::BT_W'(q_ff);
   end

   assign coef.series  = series_ff;
   assign coef.nominal = nominal_ff;
   assign coef.b5      = b5_ff;
   assign coef.bt      = bt_ff;

endmodule

// File: design/ntc_log_cell.sv
// one square-and-compare step of the log2 fraction for both operands
module ntc_log_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ntc_pkg::log_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ntc_pkg::log_type  out_data
);

   logic             valid_ff;
   ntc_pkg::log_type data_ff;
   ntc_pkg::log_type data_in;
   logic [63:0]      sqn;
   logic [63:0]      sqd;

   assign in_ready = !valid_ff || out_ready;

   // square, renormalize, shift in one fraction bit
   always_comb begin
      data_in = in_data;
      sqn = 64'(in_data.mn) * 64'(in_data.mn);
      sqd = 64'(in_data.md) * 64'(in_data.md);
      if (sqn[63]) begin
         data_in.mn = sqn[63:32];
         data_in.fn = {in_data.fn[ntc_pkg::FRAC_W-2:0], 1'b1};
      end else begin
         data_in.mn = sqn[62:31];
         data_in.fn = {in_data.fn[ntc_pkg::FRAC_W-2:0], 1'b0};
      end
      if (sqd[63]) begin
         data_in.md = sqd[63:32];
         data_in.fd = {in_data.fd[ntc_pkg::FRAC_W-2:0], 1'b1};
      end else begin
         data_in.md = sqd[62:31];
         data_in.fd = {in_data.fd[ntc_pkg::FRAC_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: design/ntc_div_cell.sv
// one restoring step of the kelvin division
module ntc_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ntc_pkg::div_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ntc_pkg::div_type  out_data
);

   logic                         valid_ff;
   ntc_pkg::div_type             data_ff;
   ntc_pkg::div_type             data_in;
   logic [ntc_pkg::DEN_W:0]      rem2;
   logic [ntc_pkg::DEN_W:0]      diff;

   assign in_ready = !valid_ff || out_ready;

   // bring down the next numerator bit, subtract when it fits
   always_comb begin
      data_in = in_data;
      rem2 = {in_data.rem, in_data.lo[ntc_pkg::QUO_BITS-1]};
      diff = rem2 - {1'b0, in_data.den};
      data_in.lo = {in_data.lo[ntc_pkg::QUO_BITS-2:0], 1'b0};
      if (!diff[ntc_pkg::DEN_W]) begin
         data_in.rem = diff[ntc_pkg::DEN_W-1:0];
         data_in.quo = {in_data.quo[ntc_pkg::QUO_BITS-2:0], 1'b1};
      end else begin
         data_in.rem = rem2[ntc_pkg::DEN_W-1:0];
         data_in.quo = {in_data.quo[ntc_pkg::QUO_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: design/ntc_adc_to_celsius.sv
// top level: thermistor ADC code to temperature in 1/16 degree Celsius
//
// Requests enter on the req_ stream: one signed ADC code per beat, taken
// across the series resistor of a divider fed from 3.3 V (3.6 V full scale).
// Each request gives exactly one response on the rsp_ stream: the temperature
// in 1/16 C in rsp_tdata and a status code in rsp_tuser (ok, code zero or
// negative, code at or above supply). Out-of-range results saturate.
// The csr_ port writes beta, series resistance and nominal resistance; it is
// always ready; the user must make writes while no request is in flight, which the block does not enforce.
// The pipe has three front stages (product, leading one, normalize),
// 24 log2 cells, four stages for ln, denominator and range check, 20 divider
// cells and two output stages. One request is taken every cycle while rsp_tready is high or bubbles remain.
// Every stage holds its own valid bit and moves on when the next stage is
// empty or moving, so a stalled receiver fills the pipe one stage at a time
// and requests keep flowing until bubbles are used up.
// Reset empties the pipe and loads the default resistor and beta values.
module ntc_adc_to_celsius (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [12:0] adc_code
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [14:0] celsius_q4
   output logic [1:0]                    rsp_tuser,   // [1:0] status
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ntc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ntc_pkg::OHM_W-1:0]     csr_data
);

   localparam int NS = ntc_pkg::LOG_STEPS;
   localparam int QS = ntc_pkg::QUO_BITS;

   ntc_pkg::coef_type coef;

   // configuration
   assign csr_ready = 1'b1;

   ntc_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   // ---------------- stage 1: clamp, classify, divider products
   logic                                 s1_valid_ff;
   ntc_pkg::side_type                    s1_side_ff, s1_side_in;
   logic [ntc_pkg::PROD_W-1:0]           s1_n_ff, s1_d_ff, s1_n_in, s1_d_in;
   logic signed [ntc_pkg::CODE_W-1:0]    code;
   logic [ntc_pkg::ADC_BITS-1:0]         cval;
   logic [ntc_pkg::LIN_W-1:0]            c36, rest;
   logic                                 adv1, adv2, adv3, adv5, adv6, adv7, adv8, adv9, adv10;

   always_comb begin
      code = signed'(req_tdata[ntc_pkg::CODE_W-1:0]);
      cval = req_tdata[ntc_pkg::ADC_BITS-1:0];
      c36  = ntc_pkg::LIN_W'({cval, 5'b0}) + ntc_pkg::LIN_W'({cval, 2'b0});
      rest = ntc_pkg::LIN_W'(ntc_pkg::TOP_CODE) - c36;
      s1_n_in = ntc_pkg::PROD_W'(coef.series) * ntc_pkg::PROD_W'(rest);
      s1_d_in = ntc_pkg::PROD_W'(c36) * ntc_pkg::PROD_W'(coef.nominal);
      s1_side_in.status    = ntc_pkg::ST_OK;
      s1_side_in.force_out = 1'b0;
      s1_side_in.fval      = ntc_pkg::Q4_MAX;
      if (code[ntc_pkg::CODE_W-1] || code == '0) begin
         s1_side_in.status    = ntc_pkg::ST_LOW;
         s1_side_in.force_out = 1'b1;
         s1_side_in.fval      = ntc_pkg::Q4_MIN;
      end else if (c36 >= ntc_pkg::LIN_W'(ntc_pkg::TOP_CODE)) begin
         s1_side_in.status    = ntc_pkg::ST_HIGH;
         s1_side_in.force_out = 1'b1;
      end
   end

   assign adv1       = !s1_valid_ff || adv2;
   assign req_tready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_side_ff <= s1_side_in;
         s1_n_ff    <= s1_n_in;
         s1_d_ff    <= s1_d_in;
      end
   end

   // ---------------- stage 2: degenerate ratios, leading ones
   logic                       s2_valid_ff;
   ntc_pkg::side_type          s2_side_ff, s2_side_in;
   logic [ntc_pkg::PROD_W-1:0] s2_n_ff, s2_d_ff;
   logic [ntc_pkg::EXP_W-1:0]  s2_en_ff, s2_ed_ff;

   always_comb begin
      s2_side_in = s1_side_ff;
      if (!s1_side_ff.force_out) begin
         if (s1_n_ff == '0) begin
            s2_side_in.force_out = 1'b1;
            s2_side_in.fval      = ntc_pkg::Q4_MAX;
         end else if (s1_d_ff == '0) begin
            s2_side_in.force_out = 1'b1;
            s2_side_in.fval      = ntc_pkg::Q4_COLD;
         end
      end
   end

   assign adv2 = !s2_valid_ff || adv3;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_side_ff <= s2_side_in;
         s2_n_ff    <= s1_n_ff;
         s2_d_ff    <= s1_d_ff;
         s2_en_ff   <= ntc_pkg::lead_one(s1_n_ff);
         s2_ed_ff   <= ntc_pkg::lead_one(s1_d_ff);
      end
   end

   // ---------------- stage 3: normalize mantissas to Q1.31
   logic                       s3_valid_ff;
   ntc_pkg::log_type           s3_data_ff, s3_data_in;
   logic [ntc_pkg::PROD_W-1:0] nsh, dsh;

   always_comb begin
      nsh = s2_n_ff << (ntc_pkg::EXP_W'(ntc_pkg::PROD_W - 1) - s2_en_ff);
      dsh = s2_d_ff << (ntc_pkg::EXP_W'(ntc_pkg::PROD_W - 1) - s2_ed_ff);
      s3_data_in.side = s2_side_ff;
      s3_data_in.mn   = nsh[ntc_pkg::PROD_W-1 -: ntc_pkg::MANT_W];
      s3_data_in.md   = dsh[ntc_pkg::PROD_W-1 -: ntc_pkg::MANT_W];
      s3_data_in.en   = s2_en_ff;
      s3_data_in.ed   = s2_ed_ff;
      s3_data_in.fn   = '0;
      s3_data_in.fd   = '0;
   end

   logic             log_valid [0:NS];
   logic             log_ready [0:NS];
   ntc_pkg::log_type log_bus   [0:NS];

   assign adv3 = !s3_valid_ff || log_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_data_ff <= s3_data_in;
      end
   end

   // ---------------- log2 fraction chain
   assign log_valid[0] = s3_valid_ff;
   assign log_bus[0]   = s3_data_ff;
   assign log_ready[NS] = adv5;

   for (genvar i = 0; i < NS; i++) begin : g_log
      ntc_log_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (log_valid[i]),
         .in_ready  (log_ready[i]),
         .in_data   (log_bus[i]),
         .out_valid (log_valid[i+1]),
         .out_ready (log_ready[i+1]),
         .out_data  (log_bus[i+1])
      );
   end

   // ---------------- stage 5: log2 ratio and magnitude
   logic                             s5_valid_ff;
   ntc_pkg::side_type                s5_side_ff;
   logic                             s5_neg_ff;
   logic [ntc_pkg::LOG_W-1:0]        s5_abs_ff;
   logic signed [ntc_pkg::LOG_W:0]   lratio;
   logic [ntc_pkg::LOG_W:0]          lneg;

   always_comb begin
      lratio = signed'({1'b0, log_bus[NS].en, log_bus[NS].fn})
             - signed'({1'b0, log_bus[NS].ed, log_bus[NS].fd});
      lneg   = -unsigned'(lratio);
   end

   assign adv5 = !s5_valid_ff || adv6;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv5) begin
         s5_valid_ff <= log_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         s5_side_ff <= log_bus[NS].side;
         s5_neg_ff  <= lratio[ntc_pkg::LOG_W];
         s5_abs_ff  <= lratio[ntc_pkg::LOG_W] ? lneg[ntc_pkg::LOG_W-1:0]
                                              : lratio[ntc_pkg::LOG_W-1:0];
      end
   end

   // ---------------- stage 6: scale by ln2
   logic              s6_valid_ff;
   ntc_pkg::side_type s6_side_ff;
   logic              s6_neg_ff;
   logic [59:0]       s6_prod_ff;

   assign adv6 = !s6_valid_ff || adv7;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv6) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv6) begin
         s6_side_ff <= s5_side_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_prod_ff <= 60'(s5_abs_ff) * 60'(ntc_pkg::LN2_Q30);
      end
   end

   // ---------------- stage 7: round, add B/298.15, check sign
   logic                      s7_valid_ff;
   ntc_pkg::side_type         s7_side_ff, s7_side_in;
   logic [ntc_pkg::DEN_W-1:0] s7_den_ff;
   logic [60:0]               rnd;
   logic signed [32:0]        term, den_s;

   always_comb begin
      rnd   = 61'(s6_prod_ff) + (61'(1) << 29);
      term  = signed'({2'b0, rnd[60:30]});
      if (s6_neg_ff) term = -term;
      den_s = signed'(33'(coef.bt)) + term;
      s7_side_in = s6_side_ff;
      if (!s6_side_ff.force_out && (den_s[32] || den_s == '0)) begin
         s7_side_in.force_out = 1'b1;
         s7_side_in.fval      = ntc_pkg::Q4_MAX;
      end
   end

   assign adv7 = !s7_valid_ff || adv8;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv7) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv7) begin
         s7_side_ff <= s7_side_in;
         s7_den_ff  <= den_s[ntc_pkg::DEN_W-1:0];
      end
   end

   // ---------------- stage 8: set up B*320*2^24 + den/2 over den
   logic                                             s8_valid_ff;
   ntc_pkg::div_type                                 s8_data_ff, s8_data_in;
   logic [ntc_pkg::B5_W+ntc_pkg::DEN_W-QS-2:0]       high;

   always_comb begin
      high = {coef.b5, s7_den_ff[ntc_pkg::DEN_W-1:QS+1]};
      s8_data_in.side = s7_side_ff;
      s8_data_in.den  = s7_den_ff;
      s8_data_in.rem  = ntc_pkg::DEN_W'(high);
      s8_data_in.lo   = s7_den_ff[QS:1];
      s8_data_in.quo  = '0;
      if (!s7_side_ff.force_out && ntc_pkg::DEN_W'(high) >= s7_den_ff) begin
         s8_data_in.side.force_out = 1'b1;
         s8_data_in.side.fval      = ntc_pkg::Q4_MAX;
      end
   end

   logic             div_valid [0:QS];
   logic             div_ready [0:QS];
   ntc_pkg::div_type div_bus   [0:QS];

   assign adv8 = !s8_valid_ff || div_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (adv8) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv8) begin
         s8_data_ff <= s8_data_in;
      end
   end

   // ---------------- kelvin divider chain
   assign div_valid[0] = s8_valid_ff;
   assign div_bus[0]   = s8_data_ff;
   assign div_ready[QS] = adv9;

   for (genvar i = 0; i < QS; i++) begin : g_div
      ntc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_data   (div_bus[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_data  (div_bus[i+1])
      );
   end

   // ---------------- stage 9: offset, divide by 20
   logic              s9_valid_ff;
   ntc_pkg::side_type s9_side_ff;
   logic [38:0]       s9_prod_ff;
   logic [QS:0]       ysum;

   assign ysum = (QS+1)'(div_bus[QS].quo) + (QS+1)'(ntc_pkg::Q4_OFFSET);
   assign adv9 = !s9_valid_ff || adv10;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (adv9) begin
         s9_valid_ff <= div_valid[QS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv9) begin
         s9_side_ff <= div_bus[QS].side;
         s9_prod_ff <= 39'(ysum[QS:2]) * 39'(ntc_pkg::DIV5_RECIP);
      end
   end

   // ---------------- stage 10: bias, saturate, output register
   logic                           s10_valid_ff;
   logic signed [ntc_pkg::Q4_W-1:0] s10_q4_ff, s10_q4_in;
   ntc_pkg::status_type            s10_status_ff;
   logic signed [17:0]             outs;

   always_comb begin
      outs = signed'({1'b0, s9_prod_ff[38:ntc_pkg::DIV5_SHIFT]}) - 18'sd5000;
      if (s9_side_ff.force_out) begin
         s10_q4_in = s9_side_ff.fval;
      end else if (outs > 18'(ntc_pkg::Q4_MAX)) begin
         s10_q4_in = ntc_pkg::Q4_MAX;
      end else if (outs < 18'(ntc_pkg::Q4_MIN)) begin
         s10_q4_in = ntc_pkg::Q4_MIN;
      end else begin
         s10_q4_in = outs[ntc_pkg::Q4_W-1:0];
      end
   end

   assign adv10 = !s10_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (adv10) begin
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv10) begin
         s10_q4_ff     <= s10_q4_in;
         s10_status_ff <= s9_side_ff.status;
      end
   end

   assign rsp_tvalid = s10_valid_ff;
   assign rsp_tdata  = {1'b0, s10_q4_ff};
   assign rsp_tuser  = s10_status_ff;

endmodule

// File: verif/ntc_adc_to_celsius_tb.sv
// testbench of the thermistor ADC code to celsius converter
module ntc_adc_to_celsius_tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PIPE_DELAY  = 60;

   // index that names no register
   localparam logic [ntc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef longint unsigned u64_type;

   typedef struct {
      logic signed [ntc_pkg::Q4_W-1:0] celsius_q4;
      ntc_pkg::status_type             status;
   } temp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [15:0]                   req_tdata = '0;    // [12:0] adc_code
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [15:0]                   rsp_tdata;         // [14:0] celsius_q4
   logic [1:0]                    rsp_tuser;         // [1:0] status
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [ntc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ntc_pkg::OHM_W-1:0]     csr_data = '0;

   // predictor copy of the registers
   u64_type beta_reg    = 3450;
   u64_type series_reg  = 10000;
   u64_type nominal_reg = 10000;

   logic [12:0] code_queue[$];
   temp_type    temp_queue[$];
   int          snd_idle = 0;
   int          rcv_idle = 0;
   bit          taken = 1'b0;
   int          errors = 0;
   int          cycles = 0;

   ntc_adc_to_celsius DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // log2 in Q.24 by square and compare
   function automatic u64_type log2_q24(u64_type x);
      int      e;
      u64_type m;
      u64_type frac;
      e = 63;
      frac = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      if (e <= 31) m = x << (31 - e);
      else m = x >> (e - 31);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd2 << 31)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (u64_type'(e) << 24) | frac;
   endfunction

   // beta equation for an in-range code
   function automatic longint beta_celsius(longint c, u64_type b);
      u64_type n, d, mag, x;
      longint  l, term, bt, den, q;
      n = series_reg * (u64_type'(ntc_pkg::TOP_CODE) - 36 * c);
      d = 36 * c * nominal_reg;
      if (n == 0) return ntc_pkg::Q4_MAX;
      if (d == 0) return ntc_pkg::Q4_COLD;
      l = longint'(log2_q24(n)) - longint'(log2_q24(d));
      mag = u64_type'(l < 0 ? -l : l) * ntc_pkg::LN2_Q30;
      mag = (mag + (64'd1 << 29)) >> 30;
      term = l < 0 ? -longint'(mag) : longint'(mag);
      bt = longint'(((20 * b << 24) + 2981) / 5963);
      den = bt + term;
      if (den <= 0) return ntc_pkg::Q4_MAX;
      x = (((b * 320) << 24) + u64_type'(den) / 2) / u64_type'(den);
      if (x > (64'd1 << 50)) return ntc_pkg::Q4_MAX;
      q = longint'((x + 12602) / 20) - 5000;
      if (q > ntc_pkg::Q4_MAX) q = ntc_pkg::Q4_MAX;
      if (q < ntc_pkg::Q4_MIN) q = ntc_pkg::Q4_MIN;
      return q;
   endfunction

   function automatic temp_type predict_temp(logic signed [12:0] code);
      temp_type t;
      longint   c;
      u64_type  b;
      c = code;
      b = (beta_reg == 0) ? 1 : beta_reg;
      if (c <= 0) begin
         t.celsius_q4 = ntc_pkg::Q4_MIN;
         t.status = ntc_pkg::ST_LOW;
      end else if (36 * c >= ntc_pkg::TOP_CODE) begin
         t.celsius_q4 = ntc_pkg::Q4_MAX;
         t.status = ntc_pkg::ST_HIGH;
      end else begin
         t.celsius_q4 = ntc_pkg::Q4_W'(beta_celsius(c, b));
         t.status = ntc_pkg::ST_OK;
      end
      return t;
   endfunction

   // request driver and response ready
   always @(negedge clock) begin
      if (!(req_tvalid && !taken)) begin
         if (!reset && code_queue.size() != 0 && $urandom_range(99) >= snd_idle) begin
            req_tvalid <= 1'b1;
            req_tdata <= {3'b000, code_queue[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      taken = 1'b0;
      rsp_tready <= !reset && ($urandom_range(99) >= rcv_idle);
   end

   // accepted requests and response checks
   always @(posedge clock) begin
      temp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            temp_queue.push_back(predict_temp(code_queue.pop_front()));
            taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (temp_queue.size() == 0) begin
               $error("unexpected response data=%0h status=%0d", rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = temp_queue.pop_front();
               if (rsp_tdata[14:0] !== want.celsius_q4) begin
                  $error("celsius_q4 expected %0d actual %0d", want.celsius_q4,
                         $signed(rsp_tdata[14:0]));
                  errors++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_tuser);
                  errors++;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_csr(logic [ntc_pkg::CSR_IDX_W-1:0] idx,
                            logic [ntc_pkg::OHM_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ntc_pkg::CSR_BETA:    beta_reg = value & 20'h3FFF;
         ntc_pkg::CSR_SERIES:  series_reg = value;
         ntc_pkg::CSR_NOMINAL: nominal_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_coefs(int beta, int series, int nominal);
      write_csr(ntc_pkg::CSR_BETA, ntc_pkg::OHM_W'(beta));
      write_csr(ntc_pkg::CSR_SERIES, ntc_pkg::OHM_W'(series));
      write_csr(ntc_pkg::CSR_NOMINAL, ntc_pkg::OHM_W'(nominal));
   endtask

   // sender holds off until the pipe is empty
   task automatic drain_pipe();
      while (code_queue.size() != 0 || temp_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DELAY) @(posedge clock);
   endtask

   task automatic push_directed();
      int corner[] = '{-4096, -2048, -1, 0, 1, 2, 3, 16, 100, 1000, 2048, 3000,
                       3753, 3754, 3755, 3756, 4094, 4095, 2730, 5461 - 8192};
      foreach (corner[i]) code_queue.push_back(13'(corner[i]));
   endtask

   // mostly codes inside the working band, some anywhere
   task automatic push_random(int count);
      repeat (count) begin
         if ($urandom_range(3) == 0) code_queue.push_back(13'($urandom));
         else code_queue.push_back(13'($urandom_range(3754, 1)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficients, sender rarely idle
      snd_idle = 6;
      rcv_idle = 72;
      push_directed();
      push_random(120);
      drain_pipe();

      set_coefs(10000, 1000000, 100);
      push_directed();
      push_random(50);
      drain_pipe();

      // receiver rarely stalls
      snd_idle = 72;
      rcv_idle = 6;
      set_coefs(1000, 100, 1000000);
      push_directed();
      push_random(50);
      drain_pipe();

      set_coefs(0, 0, 20'hFFFFF);
      push_directed();
      drain_pipe();

      // no idling at all
      snd_idle = 0;
      rcv_idle = 0;
      set_coefs(16383, 20'hFFFFF, 0);
      write_csr(CSR_UNUSED, 20'h12345);
      push_directed();
      drain_pipe();

      repeat (3) begin
         set_coefs($urandom_range(10000, 1000), $urandom_range(1000000, 100),
                   $urandom_range(1000000, 100));
         push_random(45);
         drain_pipe();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
